// ===== rtl/gh_pkg.sv =====
package gh_pkg;

  // Bound offsets are held as 63-bit prefixes; a bisection count tracks each axis.
  localparam int X_W   = 63;
  localparam int K_W   = 6;
  localparam int SYM_W = 5;
  localparam int B_W   = 64;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_LONG = 2'd2;

  // Character codes used by the decoder
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CASE_FOLD = 8'h20;

  localparam logic [5:0] NO_SYM = 6'd32;

  // Symbol value of '0' through 'Z'; NO_SYM marks unused codes
  localparam logic [5:0] SYM_TABLE [43] = '{
    6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32,
    6'd32, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16,
    6'd32, 6'd17, 6'd18, 6'd32, 6'd19, 6'd20, 6'd32,
    6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28,
    6'd29, 6'd30, 6'd31
  };

  // One classified character on its way from front to back
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             bad;
    logic             over;
    logic             last;
  } q_item_t;

  // Fold case, range check, table lookup
  function automatic logic [5:0] decode_char(logic [7:0] c);
    logic [7:0] u;
    logic [5:0] r;
    u = c;
    if (c >= CH_LO_A && c <= CH_LO_Z) u = c - CASE_FOLD;
    if (u < CH_ZERO || u > CH_UP_Z) r = NO_SYM;
    else r = SYM_TABLE[6'(u - CH_ZERO)];
    return r;
  endfunction

endpackage

// ===== rtl/gh_front.sv =====
module gh_front #(
  parameter int MAX_LEN = 22
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      char_code,
  input  logic            is_last,
  output gh_pkg::q_item_t item
);
  import gh_pkg::*;

  localparam int CW = $clog2(MAX_LEN + 2);
  localparam logic [CW-1:0] LEN_MAX = CW'(MAX_LEN);
  localparam logic [CW-1:0] LEN_SAT = CW'(MAX_LEN + 1);

  logic [CW-1:0] count;
  logic [5:0]    dec;

  // Classify the incoming character
  always_comb begin
    dec       = decode_char(char_code);
    item.sym  = dec[SYM_W-1:0];
    item.bad  = (dec == NO_SYM);
    item.over = (count >= LEN_MAX);
    item.last = is_last;
  end

  // Per-hash length count, saturating; cleared after the last character
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      if (is_last) count <= '0;
      else if (count != LEN_SAT) count <= count + CW'(1);
    end
  end

endmodule

// ===== rtl/gh_fifo.sv =====
module gh_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  gh_pkg::q_item_t push_item,
  output logic            can_push,
  input  logic            pop,
  output logic            pop_valid,
  output gh_pkg::q_item_t pop_item
);
  import gh_pkg::*;

  localparam int DEPTH = 2;

  q_item_t    mem [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign can_push  = (count != 2'(DEPTH));
  assign pop_valid = (count != 2'd0);
  assign pop_item  = mem[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule

// ===== rtl/gh_back.sv =====
module gh_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  gh_pkg::q_item_t        q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             status,
  output logic signed [63:0]     lat_low,
  output logic signed [63:0]     lat_high,
  output logic signed [63:0]     lon_low,
  output logic signed [63:0]     lon_high
);
  import gh_pkg::*;

  localparam logic [K_W-1:0] SH_BASE = K_W'(X_W - 3);
  localparam logic [K_W-1:0] K_FULL  = K_W'(X_W);
  localparam logic [K_W-1:0] K_THREE = K_W'(3);
  localparam logic [K_W-1:0] K_TWO   = K_W'(2);

  // Bisection state
  logic [X_W-1:0] lat_x, lon_x;
  logic [K_W-1:0] lat_k, lon_k;
  logic           odd;
  logic [1:0]     err;

  logic [X_W-1:0] lat_x_next, lon_x_next;
  logic [K_W-1:0] lat_k_next, lon_k_next;
  logic [1:0]     err_next;
  logic [2:0]     grp3, grp2, lat_bits, lon_bits;
  logic           refine;

  // Finish stage
  logic           fin_valid;
  logic [1:0]     fin_status;
  logic [X_W-1:0] fin_lat_x, fin_lon_x;
  logic [K_W-1:0] fin_lat_k, fin_lon_k;

  logic out_free, fin_adv, fin_free;

  // Lower bound from prefix: subtracting 2^62 only touches the top two bits
  function automatic logic [B_W-1:0] bound_lo(logic [X_W-1:0] x);
    return {~x[X_W-1], ~x[X_W-1], x[X_W-2:0]};
  endfunction

  function automatic logic [B_W-1:0] bound_hi(logic [X_W-1:0] x, logic [K_W-1:0] k);
    return bound_lo(x) + (B_W'(1) << (K_FULL - k));
  endfunction

  // Flow control through finish and output stages
  assign out_free = !out_valid || out_ready;
  assign fin_adv  = fin_valid && out_free;
  assign fin_free = !fin_valid || fin_adv;
  assign q_pop    = q_valid && (!q_item.last || fin_free);

  // Apply one classified character to the bounds
  always_comb begin
    grp3     = {q_item.sym[4], q_item.sym[2], q_item.sym[0]};
    grp2     = {q_item.sym[3], q_item.sym[1], 1'b0};
    lon_bits = odd ? grp2 : grp3;
    lat_bits = odd ? grp3 : grp2;
    refine   = !q_item.bad && !q_item.over;

    lon_x_next = lon_x;
    lat_x_next = lat_x;
    lon_k_next = lon_k;
    lat_k_next = lat_k;
    if (refine) begin
      lon_x_next = lon_x | (X_W'(lon_bits) << (SH_BASE - lon_k));
      lat_x_next = lat_x | (X_W'(lat_bits) << (SH_BASE - lat_k));
      lon_k_next = lon_k + (odd ? K_TWO : K_THREE);
      lat_k_next = lat_k + (odd ? K_THREE : K_TWO);
    end

    priority if (q_item.bad) begin
      err_next = ST_BAD;
    end else if (q_item.over && err == ST_OK) begin
      err_next = ST_LONG;
    end else begin
      err_next = err;
    end
  end

  // State registers; back to start values after the last character
  always_ff @(posedge clk) begin
    if (rst) begin
      lat_x <= '0;
      lon_x <= '0;
      lat_k <= '0;
      lon_k <= '0;
      odd   <= 1'b0;
      err   <= ST_OK;
    end else if (q_pop) begin
      if (q_item.last) begin
        lat_x <= '0;
        lon_x <= '0;
        lat_k <= '0;
        lon_k <= '0;
        odd   <= 1'b0;
        err   <= ST_OK;
      end else begin
        lat_x <= lat_x_next;
        lon_x <= lon_x_next;
        lat_k <= lat_k_next;
        lon_k <= lon_k_next;
        odd   <= odd ^ refine;
        err   <= err_next;
      end
    end
  end

  // Finish stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (q_pop && q_item.last) begin
      fin_valid <= 1'b1;
    end else if (fin_adv) begin
      fin_valid <= 1'b0;
    end
  end

  // Finish stage payload
  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) begin
      fin_status <= err_next;
      fin_lat_x  <= lat_x_next;
      fin_lon_x  <= lon_x_next;
      fin_lat_k  <= lat_k_next;
      fin_lon_k  <= lon_k_next;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fin_valid;
    end
  end

  // Output payload: bounds forced to zero on any error
  always_ff @(posedge clk) begin
    if (fin_adv) begin
      status <= fin_status;
      if (fin_status == ST_OK) begin
        lat_low  <= bound_lo(fin_lat_x);
        lat_high <= bound_hi(fin_lat_x, fin_lat_k);
        lon_low  <= bound_lo(fin_lon_x);
        lon_high <= bound_hi(fin_lon_x, fin_lon_k);
      end else begin
        lat_low  <= '0;
        lat_high <= '0;
        lon_low  <= '0;
        lon_high <= '0;
      end
    end
  end

endmodule

// ===== rtl/geohash_decoder.sv =====
// Geohash decoder: one character per cycle, back to back, through a two-entry queue,
// while finished results are taken; the back end refines bounds with bit sets only.
// Result path: the last character pops from the queue into the finish stage, then the
// upper-bound add feeds the output register.
// Reset (rst, synchronous, active high) empties the queue and pipeline and restarts the hash.
module geohash_decoder #(
  parameter int MAX_LEN = 22
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         char_code,
  input  logic               is_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [63:0] lat_low,
  output logic signed [63:0] lat_high,
  output logic signed [63:0] lon_low,
  output logic signed [63:0] lon_high
);
  import gh_pkg::*;

  logic    accept;
  q_item_t f_item;
  q_item_t q_item;
  logic    q_valid;
  logic    q_pop;

  assign accept = in_valid && in_ready;

  // Classifier
  gh_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (char_code),
    .is_last   (is_last),
    .item      (f_item)
  );

  // Decoupling queue
  gh_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_item (f_item),
    .can_push  (in_ready),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_item)
  );

  // Bisection and result
  gh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .lat_low   (lat_low),
    .lat_high  (lat_high),
    .lon_low   (lon_low),
    .lon_high  (lon_high)
  );

endmodule

// ===== rtl/gh_checker.sv =====
module gh_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         status,
  input logic signed [63:0] lat_low,
  input logic signed [63:0] lat_high,
  input logic signed [63:0] lon_low,
  input logic signed [63:0] lon_high
);
  import gh_pkg::*;

  localparam logic signed [63:0] BOUND_POS = 64'sh4000000000000000;
  localparam logic signed [63:0] BOUND_NEG = -64'sh4000000000000000;

  // A result held back stays valid with status and low bounds unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(lat_low)
      && $stable(lon_low))
    else $error("stalled result changed");

  // Reset clears the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_BAD || status == ST_LONG))
    else $error("undefined status code");

  // Errors carry zero bounds
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> lat_low == 0 && lat_high == 0
      && lon_low == 0 && lon_high == 0)
    else $error("nonzero bounds on error result");

  // Good results are nonempty intervals inside the full range
  a_bounds_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> lat_low < lat_high && lon_low < lon_high
      && lat_low >= BOUND_NEG && lon_low >= BOUND_NEG
      && lat_high <= BOUND_POS && lon_high <= BOUND_POS)
    else $error("bounds out of order or range");

endmodule

bind geohash_decoder gh_checker u_gh_checker (.*);

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gh_pkg::*;

  localparam int HASH_MAX = 22;
  localparam logic signed [63:0] BOUND_ONE = 64'sh4000_0000_0000_0000;

  // One decoded cell: status plus the four bounds
  typedef struct {
    logic [1:0]         st;
    logic signed [63:0] lat_lo;
    logic signed [63:0] lat_hi;
    logic signed [63:0] lon_lo;
    logic signed [63:0] lon_hi;
  } cell_bounds_t;

  // Scoreboard: bisects its own copy of the bounds and holds the cells still due
  class geohash_board;
    logic signed [63:0] lat_lo, lat_hi, lon_lo, lon_hi;
    bit                 lat_turn;
    logic [1:0]         err;
    int unsigned        count;
    cell_bounds_t       boxes[$];
    int                 fails;

    function new();
      fails = 0;
      restart();
    endfunction

    function void restart();
      lat_lo   = -BOUND_ONE;
      lat_hi   = BOUND_ONE;
      lon_lo   = -BOUND_ONE;
      lon_hi   = BOUND_ONE;
      lat_turn = 1'b0;
      err      = ST_OK;
      count    = 0;
    endfunction

    // ASCII character of a base-32 symbol value
    static function logic [7:0] char_of(int v);
      string s;
      s = "0123456789BCDEFGHJKMNPQRSTUVWXYZ";
      return s[v];
    endfunction

    // Symbol value of a character, -1 when it is not part of the alphabet
    static function int sym_of(logic [7:0] c);
      logic [7:0] u;
      u = c;
      if (c >= CH_LO_A && c <= CH_LO_Z) u = c - CASE_FOLD;
      for (int i = 0; i < 32; i++) begin
        if (char_of(i) == u) return i;
      end
      return -1;
    endfunction

    // Exact midpoint; the sum never leaves the signed range
    static function logic signed [63:0] mid(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      return s >>> 1;
    endfunction

    function int pending();
      return boxes.size();
    endfunction

    task flag(string what);
      $display("%0t mismatch: %s", $time, what);
      fails++;
    endtask

    // Accepted character: refine the bounds, queue a cell on the last one
    function void take_char(logic [7:0] c, logic last);
      int           sym;
      bit           over;
      bit           on_lon;
      logic [4:0]   b;
      logic signed [63:0] m;
      cell_bounds_t box;
      sym  = sym_of(c);
      over = (count >= HASH_MAX);
      if (count < HASH_MAX + 1) count++;
      if (sym < 0) begin
        err = ST_BAD;
      end else if (over) begin
        if (err == ST_OK) err = ST_LONG;
      end else begin
        b = sym[4:0];
        for (int k = 4; k >= 0; k--) begin
          on_lon = ((k % 2) == 0) != lat_turn;
          if (on_lon) begin
            m = mid(lon_lo, lon_hi);
            if (b[k]) lon_lo = m;
            else lon_hi = m;
          end else begin
            m = mid(lat_lo, lat_hi);
            if (b[k]) lat_lo = m;
            else lat_hi = m;
          end
        end
        lat_turn = ~lat_turn;
      end
      if (last) begin
        box.st = err;
        if (err == ST_OK) begin
          box.lat_lo = lat_lo;
          box.lat_hi = lat_hi;
          box.lon_lo = lon_lo;
          box.lon_hi = lon_hi;
        end else begin
          box.lat_lo = '0;
          box.lat_hi = '0;
          box.lon_lo = '0;
          box.lon_hi = '0;
        end
        boxes.push_back(box);
        restart();
      end
    endfunction

    // Accepted result: compare with the oldest cell due
    task check_box(logic [1:0] st, logic signed [63:0] la_lo, logic signed [63:0] la_hi,
                   logic signed [63:0] lo_lo, logic signed [63:0] lo_hi);
      cell_bounds_t e;
      if (boxes.size() == 0) begin
        flag("result transfer with nothing expected");
      end else begin
        e = boxes.pop_front();
        if (st !== e.st)
          flag($sformatf("status got %0d want %0d", st, e.st));
        if (la_lo !== e.lat_lo)
          flag($sformatf("lat_low got %h want %h", la_lo, e.lat_lo));
        if (la_hi !== e.lat_hi)
          flag($sformatf("lat_high got %h want %h", la_hi, e.lat_hi));
        if (lo_lo !== e.lon_lo)
          flag($sformatf("lon_low got %h want %h", lo_lo, e.lon_lo));
        if (lo_hi !== e.lon_hi)
          flag($sformatf("lon_high got %h want %h", lo_hi, e.lon_hi));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         char_code = '0;
  logic               is_last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic signed [63:0] lat_low, lat_high, lon_low, lon_high;

  bit                 no_idle = 1'b0;
  int unsigned        chars_sent = 0;
  geohash_board       board;

  geohash_decoder #(.MAX_LEN(HASH_MAX)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .is_last   (is_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .lat_low   (lat_low),
    .lat_high  (lat_high),
    .lon_low   (lon_low),
    .lon_high  (lon_high)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #5_000_000;
    $display("[geohash_decoder] ERROR");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random alphabet character, letters in either case
  function automatic logic [7:0] rand_valid_char();
    logic [7:0] c;
    c = geohash_board::char_of($urandom_range(0, 31));
    if (c > 8'h39 && $urandom_range(0, 1) == 1) c = c + CASE_FOLD;
    return c;
  endfunction

  function automatic logic [7:0] rand_bad_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (geohash_board::sym_of(c) >= 0);
    return c;
  endfunction

  // Sample both transfers at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.take_char(char_code, is_last);
      if (out_valid && out_ready) board.check_box(status, lat_low, lat_high, lon_low, lon_high);
    end
  end

  // Result side: bursts of ready with random stalls between them
  initial begin
    int n, g;
    forever begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        @(negedge clk);
        out_ready = 1'b1;
      end
      g = no_idle ? 0 : gap_len();
      repeat (g) begin
        @(negedge clk);
        out_ready = 1'b0;
      end
    end
  end

  // Called at a falling edge, returns at a falling edge after the transfer
  task automatic send_char(input logic [7:0] c, input logic last);
    int g;
    g = no_idle ? 0 : gap_len();
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid  = 1'b1;
    char_code = c;
    is_last   = last;
    do @(posedge clk);
    while (!in_ready);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_hash(input logic [7:0] s[$]);
    for (int i = 0; i < s.size(); i++) send_char(s[i], i == s.size() - 1);
  endtask

  // Hold off the sender until every cell has come back
  task automatic drain();
    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Random hash: mostly well formed, some too long, some broken, some noise
  task automatic build_hash(output logic [7:0] s[$]);
    int r, len, pos;
    s = {};
    r = $urandom_range(0, 99);
    if (r < 55) len = $urandom_range(1, 12);
    else if (r < 70) len = $urandom_range(13, HASH_MAX);
    else if (r < 75) len = HASH_MAX;
    else if (r < 85) len = $urandom_range(HASH_MAX + 1, HASH_MAX + 4);
    else if (r < 92) len = $urandom_range(1, HASH_MAX + 3);
    else len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      if (r >= 92) s.push_back(8'($urandom_range(0, 255)));
      else s.push_back(rand_valid_char());
    end
    if (r >= 85 && r < 92) begin
      pos = $urandom_range(0, len - 1);
      s[pos] = rand_bad_char();
    end
  endtask

  initial begin
    logic [7:0] singles[$];
    logic [7:0] h[$];
    int         n_hash;
    board = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: symbol extremes, both cases, every kind of bad code
    singles = {8'h30, 8'h39, 8'h62, 8'h42, 8'h5A, 8'h7A, 8'h00, 8'hFF, 8'h2F, 8'h3A,
               8'h40, 8'h41, 8'h49, 8'h4C, 8'h4F, 8'h5B, 8'h60, 8'h7B, 8'h80, 8'h69};
    foreach (singles[i]) begin
      h = {};
      h.push_back(singles[i]);
      send_hash(h);
    end
    // Bad first character keeps the error through good ones, then an all-valid hash in both cases
    h = {8'h61, 8'h30};
    send_hash(h);
    h = {8'h7A, 8'h30, 8'h5A};
    send_hash(h);
    drain();

    // Random part
    n_hash = 0;
    while (chars_sent < 900) begin
      no_idle = ($urandom_range(0, 4) == 0);
      build_hash(h);
      send_hash(h);
      n_hash++;
      if (n_hash % 15 == 0) drain();
    end

    no_idle = 1'b0;
    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (board.pending() != 0) board.flag("cells left without a result");
    if (board.fails == 0) begin
      $display("[geohash_decoder] OK");
    end else begin
      $display("[geohash_decoder] ERROR");
    end
    $finish;
  end

endmodule
